>>> src/mpd_pkg.sv
// Shared constants and types for the masked pairwise distance core.
package mpd_pkg;

  localparam int unsigned MAX_ROWS_DEFAULT   = 4096;
  localparam int unsigned VALUE_BITS_DEFAULT = 24;
  localparam int unsigned QUEUE_DEPTH        = 2;
  localparam int unsigned DIST_W             = 64;
  localparam int unsigned METHOD_W           = 2;
  localparam int unsigned HALF_W             = DIST_W / 2;

  typedef enum logic [METHOD_W-1:0] {
    METHOD_SQ_EUCLID = 2'd0,
    METHOD_MANHATTAN = 2'd1,
    METHOD_MEAN_SQ   = 2'd2
  } method_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV_Q,
    BK_MUL_LO,
    BK_MUL_HI,
    BK_MUL_R,
    BK_DIV_R,
    BK_DONE
  } back_state_e;

endpackage

>>> src/mpd_if.sv
// Row and result channel interfaces for the masked pairwise distance core.
interface mpd_row_if import mpd_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEFAULT
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value_a;
  logic signed [VALUE_BITS-1:0] value_b;
  logic                         missing_a;
  logic                         missing_b;
  logic                         last_row;

  modport source (
    output valid, value_a, value_b, missing_a, missing_b, last_row,
    input  ready
  );
  modport sink (
    input  valid, value_a, value_b, missing_a, missing_b, last_row,
    output ready
  );
endinterface

interface mpd_res_if import mpd_pkg::*; #(
  parameter int unsigned CNT_W = $clog2(MAX_ROWS_DEFAULT + 1)
);
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance;
  logic              is_infinite;
  logic [CNT_W-1:0]  pairs_used;

  modport source (
    output valid, distance, is_infinite, pairs_used,
    input  ready
  );
  modport sink (
    input  valid, distance, is_infinite, pairs_used,
    output ready
  );
endinterface

>>> src/mpd_front.sv
// Row front end: difference, term and masked accumulation, one row per cycle unless a finished job waits for the queue.
module mpd_front import mpd_pkg::*; #(
  parameter int unsigned MAX_ROWS   = MAX_ROWS_DEFAULT,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEFAULT,
  parameter int unsigned CNT_W      = $clog2(MAX_ROWS + 1),
  parameter int unsigned JOB_W      = DIST_W + 2 * CNT_W + METHOD_W
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [METHOD_W-1:0] method_i,
  mpd_row_if.sink             row_i,
  output logic                job_valid_o,
  input  logic                job_ready_i,
  output logic [JOB_W-1:0]    job_o
);

  localparam int unsigned AbsW = VALUE_BITS + 1;
  localparam int unsigned MulW = (AbsW > HALF_W) ? HALF_W : AbsW;
  localparam logic [CNT_W-1:0] RowLimit = CNT_W'(MAX_ROWS);

  logic signed [AbsW-1:0] diff;
  logic [AbsW-1:0]        abs_diff;
  logic                   advance;

  logic                   s1_vld_q, s1_use_q, s1_last_q;
  logic [AbsW-1:0]        s1_abs_q;
  logic                   s2_vld_q, s2_use_q, s2_last_q;
  logic [DIST_W-1:0]      s2_term_q;

  logic [MulW-1:0]        mul_op;
  logic [2*MulW-1:0]      square;
  logic                   abs_ovf;
  logic [DIST_W-1:0]      term_d;

  logic [DIST_W-1:0]      sum_q;
  logic [CNT_W-1:0]       rows_q, valid_q;
  logic [DIST_W:0]        sum_add;
  logic [DIST_W-1:0]      sum_next;
  logic [CNT_W-1:0]       rows_next, valid_next;

  assign diff     = AbsW'(row_i.value_a) - AbsW'(row_i.value_b);
  assign abs_diff = diff[AbsW-1] ? AbsW'(-diff) : AbsW'(diff);

  assign advance     = !(s2_vld_q && s2_last_q && !job_ready_i);
  assign row_i.ready = advance;

  assign mul_op = s1_abs_q[MulW-1:0];
  assign square = mul_op * mul_op;

  generate
    if (AbsW > HALF_W) begin : g_abs_ovf
      assign abs_ovf = |s1_abs_q[AbsW-1:HALF_W];
    end else begin : g_abs_fits
      assign abs_ovf = 1'b0;
    end
  endgenerate

  always_comb begin
    if (method_i == METHOD_MANHATTAN) begin
      term_d = DIST_W'(s1_abs_q);
    end else if (abs_ovf) begin
      term_d = '1;
    end else begin
      term_d = DIST_W'(square);
    end
  end

  assign sum_add    = {1'b0, sum_q} + {1'b0, s2_term_q};
  assign sum_next   = !s2_use_q ? sum_q : (sum_add[DIST_W] ? '1 : sum_add[DIST_W-1:0]);
  assign rows_next  = (rows_q < RowLimit) ? rows_q + 1'b1 : rows_q;
  assign valid_next = (s2_use_q && (valid_q < RowLimit)) ? valid_q + 1'b1 : valid_q;

  assign job_valid_o = s2_vld_q && s2_last_q;
  assign job_o       = {method_i, rows_next, valid_next, sum_next};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      sum_q    <= '0;
      rows_q   <= '0;
      valid_q  <= '0;
    end else if (advance) begin
      s1_vld_q <= row_i.valid;
      s2_vld_q <= s1_vld_q;
      if (s2_vld_q) begin
        if (s2_last_q) begin
          sum_q   <= '0;
          rows_q  <= '0;
          valid_q <= '0;
        end else begin
          sum_q   <= sum_next;
          rows_q  <= rows_next;
          valid_q <= valid_next;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_use_q  <= !row_i.missing_a && !row_i.missing_b;
      s1_last_q <= row_i.last_row;
      s1_abs_q  <= abs_diff;
      s2_use_q  <= s1_use_q;
      s2_last_q <= s1_last_q;
      s2_term_q <= term_d;
    end
  end

endmodule

>>> src/mpd_queue.sv
// Short job queue between the row front end and the scaling back end.
module mpd_queue import mpd_pkg::*; #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output logic [DATA_W-1:0] pop_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              push, pop;

  assign push_ready_o = count_q != CntW'(DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> src/mpd_div.sv
// Restoring divider, one quotient bit per cycle, 64-bit dividend.
module mpd_div import mpd_pkg::*; #(
  parameter int unsigned DIV_W = 13
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIST_W-1:0] dividend_i,
  input  logic [DIV_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [DIST_W-1:0] quotient_o,
  output logic [DIV_W-1:0]  remainder_o
);

  localparam int unsigned StepW = $clog2(DIST_W);

  logic [DIST_W-1:0] quo_q;
  logic [DIV_W-1:0]  rem_q, divisor_q;
  logic [StepW-1:0]  step_q;
  logic              busy_q, done_q;
  logic [DIV_W:0]    trial;
  logic              fits;

  assign trial       = {rem_q, quo_q[DIST_W-1]};
  assign fits        = trial >= {1'b0, divisor_q};
  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == StepW'(DIST_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q     <= dividend_i;
      rem_q     <= '0;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIST_W-2:0], fits};
      rem_q <= fits ? DIV_W'(trial - {1'b0, divisor_q}) : DIV_W'(trial);
    end
  end

endmodule

>>> src/mpd_back.sv
// Back end: scales or averages each finished sum and holds the result.
module mpd_back import mpd_pkg::*; #(
  parameter int unsigned CNT_W = $clog2(MAX_ROWS_DEFAULT + 1),
  parameter int unsigned JOB_W = DIST_W + 2 * CNT_W + METHOD_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  output logic             job_ready_o,
  input  logic [JOB_W-1:0] job_i,
  mpd_res_if.source        res_o
);

  localparam int unsigned ProdW = HALF_W + CNT_W;
  localparam int unsigned FullW = ProdW + HALF_W + 1;

  back_state_e state_q, state_d;

  logic [DIST_W-1:0]   job_sum;
  logic [CNT_W-1:0]    job_valid, job_rows;
  logic [METHOD_W-1:0] job_method;

  logic [CNT_W-1:0]    valid_q, rows_q;
  logic [METHOD_W-1:0] method_q;
  logic [DIST_W-1:0]   quo_q;
  logic [CNT_W-1:0]    rem_q;
  logic [ProdW-1:0]    plo_q, phi_q;
  logic [DIST_W-1:0]   hi_q;
  logic                ovf_q;
  logic [DIST_W-1:0]   res_dist_q;
  logic                res_inf_q;

  logic                out_vld_q, out_inf_q, out_load;
  logic [DIST_W-1:0]   out_dist_q;
  logic [CNT_W-1:0]    out_pairs_q;

  logic                div_start, div_done;
  logic [DIST_W-1:0]   div_dividend, div_quo;
  logic [CNT_W-1:0]    div_divisor, div_rem;

  logic [HALF_W-1:0]   mul_a;
  logic [ProdW-1:0]    mul_res;
  logic [FullW-1:0]    full_sum;
  logic [DIST_W:0]     final_add;

  assign job_sum    = job_i[DIST_W-1:0];
  assign job_valid  = job_i[DIST_W +: CNT_W];
  assign job_rows   = job_i[DIST_W + CNT_W +: CNT_W];
  assign job_method = job_i[JOB_W-1 -: METHOD_W];

  always_comb begin
    case (state_q)
      BK_MUL_LO: mul_a = quo_q[HALF_W-1:0];
      BK_MUL_HI: mul_a = quo_q[DIST_W-1:HALF_W];
      BK_MUL_R:  mul_a = HALF_W'(rem_q);
      default:   mul_a = '0;
    endcase
  end

  assign mul_res   = ProdW'(mul_a) * ProdW'(rows_q);
  assign full_sum  = {phi_q, {HALF_W{1'b0}}} + FullW'(plo_q);
  assign final_add = {1'b0, hi_q} + {1'b0, div_quo};

  mpd_div #(
    .DIV_W(CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo),
    .remainder_o(div_rem)
  );

  always_comb begin
    state_d      = state_q;
    job_ready_o  = 1'b0;
    div_start    = 1'b0;
    div_dividend = job_sum;
    div_divisor  = job_valid;
    out_load     = 1'b0;
    case (state_q)
      BK_IDLE: begin
        job_ready_o = 1'b1;
        if (job_valid_i) begin
          if (job_valid == '0) begin
            state_d = BK_DONE;
          end else begin
            div_start = 1'b1;
            state_d   = BK_DIV_Q;
          end
        end
      end
      BK_DIV_Q: begin
        if (div_done) begin
          if (method_q == METHOD_SQ_EUCLID || method_q == METHOD_MANHATTAN) begin
            state_d = BK_MUL_LO;
          end else begin
            state_d = BK_DONE;
          end
        end
      end
      BK_MUL_LO: state_d = BK_MUL_HI;
      BK_MUL_HI: state_d = BK_MUL_R;
      BK_MUL_R: begin
        div_start    = 1'b1;
        div_dividend = DIST_W'(mul_res);
        div_divisor  = valid_q;
        state_d      = BK_DIV_R;
      end
      BK_DIV_R: begin
        if (div_done) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!out_vld_q || res_o.ready) begin
          out_load = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          valid_q    <= job_valid;
          rows_q     <= job_rows;
          method_q   <= job_method;
          res_dist_q <= '1;
          res_inf_q  <= job_valid == '0;
        end
      end
      BK_DIV_Q: begin
        if (div_done) begin
          quo_q      <= div_quo;
          rem_q      <= div_rem;
          res_dist_q <= div_quo;
        end
      end
      BK_MUL_LO: plo_q <= mul_res;
      BK_MUL_HI: phi_q <= mul_res;
      BK_MUL_R: begin
        hi_q  <= full_sum[DIST_W-1:0];
        ovf_q <= |full_sum[FullW-1:DIST_W];
      end
      BK_DIV_R: begin
        if (div_done) begin
          res_dist_q <= (ovf_q || final_add[DIST_W]) ? '1 : final_add[DIST_W-1:0];
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_dist_q  <= res_dist_q;
      out_inf_q   <= res_inf_q;
      out_pairs_q <= valid_q;
    end
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.distance    = out_dist_q;
  assign res_o.is_infinite = out_inf_q;
  assign res_o.pairs_used  = out_pairs_q;

endmodule

>>> src/masked_pairwise_distance_core.sv
// Masked pairwise distance core: top level.
//
// Rows of a column pair enter on row_i (valid/ready), one per cycle while
// ready is high. Each carries two signed fixed-point values, their missing
// flags and a last-row mark. Rows with both values present add a squared or
// absolute difference to the running sum, per the method register (cfg_we_i
// and cfg_wdata_i, written while the core is idle).
// The transaction with last_row set closes the pair: one result transaction
// leaves on res_o with the scaled distance, an infinite flag and the count
// of rows used. Other rows produce nothing.
// The front end takes one row per cycle while row_i.ready is high; a row
// passes the s1 and s2 registers before it reaches the accumulator, and a
// two-entry job queue lets it run on into the next pair.
// The back end shares one 1-bit-per-cycle divider over a 64-bit dividend.
// Mean squared difference takes one division; the scaled methods divide,
// multiply quotient and remainder by the row count, then divide again. It
// takes the next job only once the result is in the output register.
// Reset clears the sums, counters, queue and the method register (squared
// euclidean). When res_o is stalled the result is held in its output
// register; the back end then stops, the queue fills and row_i.ready drops.
module masked_pairwise_distance_core import mpd_pkg::*; #(
  parameter int unsigned MAX_ROWS   = MAX_ROWS_DEFAULT,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [METHOD_W-1:0] cfg_wdata_i,
  mpd_row_if.sink             row_i,
  mpd_res_if.source           res_o
);

  localparam int unsigned CntW = $clog2(MAX_ROWS + 1);
  localparam int unsigned JobW = DIST_W + 2 * CntW + METHOD_W;

  logic [METHOD_W-1:0] method_q;
  logic                push_valid, push_ready, pop_valid, pop_ready;
  logic [JobW-1:0]     push_job, pop_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_q <= METHOD_W'(METHOD_SQ_EUCLID);
    end else if (cfg_we_i) begin
      method_q <= cfg_wdata_i;
    end
  end

  mpd_front #(
    .MAX_ROWS  (MAX_ROWS),
    .VALUE_BITS(VALUE_BITS),
    .CNT_W     (CntW),
    .JOB_W     (JobW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .method_i   (method_q),
    .row_i      (row_i),
    .job_valid_o(push_valid),
    .job_ready_i(push_ready),
    .job_o      (push_job)
  );

  mpd_queue #(
    .DATA_W(JobW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_job),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_job)
  );

  mpd_back #(
    .CNT_W(CntW),
    .JOB_W(JobW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(pop_valid),
    .job_ready_o(pop_ready),
    .job_i      (pop_job),
    .res_o      (res_o)
  );

endmodule

>>> src/mpd_checker.sv
// Port-level checks on the result channel, bound to the core.
module mpd_checker import mpd_pkg::*; #(
  parameter int unsigned MAX_ROWS = MAX_ROWS_DEFAULT,
  parameter int unsigned CNT_W    = $clog2(MAX_ROWS + 1)
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              res_valid_i,
  input logic              res_ready_i,
  input logic [DIST_W-1:0] res_distance_i,
  input logic              res_is_infinite_i,
  input logic [CNT_W-1:0]  res_pairs_used_i
);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_distance_i)
      && $stable(res_is_infinite_i) && $stable(res_pairs_used_i))
    else $error("result changed while stalled");

  a_inf_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_is_infinite_i |-> (&res_distance_i) && res_pairs_used_i == '0)
    else $error("infinite result without all-ones distance and zero pairs");

  a_pairs_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_is_infinite_i |->
      res_pairs_used_i != '0 && res_pairs_used_i <= CNT_W'(MAX_ROWS))
    else $error("finite result with pair count out of range");

endmodule

bind masked_pairwise_distance_core mpd_checker #(
  .MAX_ROWS(MAX_ROWS)
) u_mpd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .res_valid_i      (res_o.valid),
  .res_ready_i      (res_o.ready),
  .res_distance_i   (res_o.distance),
  .res_is_infinite_i(res_o.is_infinite),
  .res_pairs_used_i (res_o.pairs_used)
);

>>> verif/mpd_distance_checker.sv
`timescale 1ns / 1ps
// Scoreboard that predicts each pair's distance from the observed rows and checks the result channel.
module mpd_distance_checker import mpd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [METHOD_W-1:0] cfg_wdata_i,
  mpd_row_if                  row_mon,
  mpd_res_if                  res_mon,
  output int                  pending_o,
  output int                  fail_count_o
);

  localparam int unsigned CNT_W = $clog2(MAX_ROWS_DEFAULT + 1);
  localparam int unsigned WIDE_W = 2 * DIST_W;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              is_infinite;
    logic [CNT_W-1:0]  pairs_used;
  } dist_result_t;

  logic [METHOD_W-1:0] method_reg;
  logic [DIST_W-1:0]   sum_acc;
  int unsigned         used_rows;
  int unsigned         seen_rows;
  dist_result_t        expected_dist_q[$];
  int                  fails = 0;

  assign fail_count_o = fails;

  task automatic report_mismatch(input string what, input logic [DIST_W-1:0] got,
                                 input logic [DIST_W-1:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    fails++;
  endtask

  task automatic predict_row();
    logic signed [DIST_W-1:0] a;
    logic signed [DIST_W-1:0] b;
    logic signed [DIST_W-1:0] diff;
    logic [DIST_W-1:0]        mag;
    logic [DIST_W-1:0]        term;
    logic [DIST_W:0]          total;
    logic [WIDE_W-1:0]        scaled;
    dist_result_t             want;
    a = row_mon.value_a;
    b = row_mon.value_b;
    if (seen_rows < MAX_ROWS_DEFAULT) seen_rows++;
    if (!row_mon.missing_a && !row_mon.missing_b) begin
      diff = a - b;
      mag  = diff[DIST_W-1] ? -diff : diff;
      if (method_reg == METHOD_MANHATTAN) begin
        term = mag;
      end else if (mag > 64'hFFFF_FFFF) begin
        term = '1;
      end else begin
        term = mag * mag;
      end
      total   = {1'b0, sum_acc} + {1'b0, term};
      sum_acc = total[DIST_W] ? '1 : total[DIST_W-1:0];
      if (used_rows < MAX_ROWS_DEFAULT) used_rows++;
    end
    if (row_mon.last_row) begin
      if (used_rows == 0) begin
        want.distance    = '1;
        want.is_infinite = 1'b1;
        want.pairs_used  = '0;
      end else begin
        if (method_reg == METHOD_SQ_EUCLID || method_reg == METHOD_MANHATTAN) begin
          scaled = WIDE_W'(sum_acc) * WIDE_W'(seen_rows);
          scaled = scaled / WIDE_W'(used_rows);
          want.distance = (scaled[WIDE_W-1:DIST_W] != '0) ? '1 : scaled[DIST_W-1:0];
        end else begin
          want.distance = sum_acc / DIST_W'(used_rows);
        end
        want.is_infinite = 1'b0;
        want.pairs_used  = CNT_W'(used_rows);
      end
      expected_dist_q.push_back(want);
      sum_acc   = '0;
      used_rows = 0;
      seen_rows = 0;
    end
  endtask

  task automatic check_result();
    dist_result_t want;
    if (expected_dist_q.size() == 0) begin
      report_mismatch("result with nothing expected, distance", res_mon.distance, '0);
    end else begin
      want = expected_dist_q.pop_front();
      if (res_mon.distance !== want.distance)
        report_mismatch("distance", res_mon.distance, want.distance);
      if (res_mon.is_infinite !== want.is_infinite)
        report_mismatch("is_infinite", DIST_W'(res_mon.is_infinite), DIST_W'(want.is_infinite));
      if (res_mon.pairs_used !== want.pairs_used)
        report_mismatch("pairs_used", DIST_W'(res_mon.pairs_used), DIST_W'(want.pairs_used));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_reg = METHOD_SQ_EUCLID;
      sum_acc    = '0;
      used_rows  = 0;
      seen_rows  = 0;
      expected_dist_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) method_reg = cfg_wdata_i;
      if (res_mon.valid && res_mon.ready) check_result();
      if (row_mon.valid && row_mon.ready) predict_row();
      pending_o <= expected_dist_q.size();
    end
  end

endmodule

>>> verif/masked_pairwise_distance_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for the masked pairwise distance core: row stimulus, config phases and verdict.
module masked_pairwise_distance_core_tb;
  import mpd_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 800000;
  localparam int unsigned RANDOM_ROWS    = 700;
  localparam int unsigned PHASES         = 8;
  localparam int unsigned SETTLE_CYCLES  = 20;
  localparam int unsigned DRAIN_CYCLES   = 200;

  typedef logic signed [VALUE_BITS_DEFAULT-1:0] value_t;

  localparam value_t VAL_MAX = {1'b0, {(VALUE_BITS_DEFAULT-1){1'b1}}};
  localparam value_t VAL_MIN = {1'b1, {(VALUE_BITS_DEFAULT-1){1'b0}}};

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [METHOD_W-1:0] cfg_wdata;
  int                  pending;
  int                  fail_count;
  int unsigned         cycles = 0;
  int unsigned         rows_sent = 0;
  bit                  src_burst = 1'b0;
  bit                  snk_burst = 1'b0;

  mpd_row_if row_if ();
  mpd_res_if res_if ();

  masked_pairwise_distance_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .row_i       (row_if),
    .res_o       (res_if)
  );

  mpd_distance_checker dist_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .row_mon      (row_if),
    .res_mon      (res_if),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic value_t rand_value();
    case ($urandom_range(0, 5))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return value_t'($urandom_range(0, 255)) - value_t'(128);
      default: return value_t'($urandom());
    endcase
  endfunction

  task automatic send_row(input value_t a, input value_t b, input bit miss_a,
                          input bit miss_b, input bit last);
    int unsigned gap;
    gap = src_burst ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      row_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    row_if.valid     <= 1'b1;
    row_if.value_a   <= a;
    row_if.value_b   <= b;
    row_if.missing_a <= miss_a;
    row_if.missing_b <= miss_b;
    row_if.last_row  <= last;
    do @(posedge clk); while (!(row_if.valid && row_if.ready));
    rows_sent++;
  endtask

  task automatic send_pair(input int unsigned len, input int unsigned miss_pct);
    value_t a;
    value_t b;
    for (int unsigned i = 1; i <= len; i++) begin
      a = rand_value();
      if ($urandom_range(0, 2) == 0) begin
        b = a + value_t'($urandom_range(0, 63)) - value_t'(32);
      end else begin
        b = rand_value();
      end
      send_row(a, b, $urandom_range(1, 100) <= miss_pct, $urandom_range(1, 100) <= miss_pct,
               i == len);
    end
  endtask

  // Drain every outstanding result and let the back end settle before a write.
  task automatic set_method(input logic [METHOD_W-1:0] method);
    row_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= method;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    res_if.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      int unsigned stall;
      stall = snk_burst ? 0 : $urandom_range(0, 10);
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!(res_if.valid && res_if.ready));
      snk_burst = ($urandom_range(0, 4) == 0);
    end
  end

  initial begin
    int unsigned phase_end;
    int unsigned miss_pct;
    row_if.valid     <= 1'b0;
    row_if.value_a   <= '0;
    row_if.value_b   <= '0;
    row_if.missing_a <= 1'b0;
    row_if.missing_b <= 1'b0;
    row_if.last_row  <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= METHOD_SQ_EUCLID;
    rst_n            <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Method 0 runs on the reset value; the others are written.
    for (int m = 0; m < 4; m++) begin
      if (m != 0) set_method(METHOD_W'(m));
      src_burst = m[0];
      send_row(VAL_MAX, VAL_MIN, 1'b0, 1'b0, 1'b1);
      send_row(VAL_MIN, VAL_MAX, 1'b0, 1'b0, 1'b0);
      send_row('0, '0, 1'b1, 1'b0, 1'b0);
      send_row(value_t'(5), value_t'(5), 1'b0, 1'b1, 1'b1);
      send_row(VAL_MAX, VAL_MAX, 1'b1, 1'b1, 1'b1);
    end

    rows_sent = 0;
    for (int p = 0; rows_sent < RANDOM_ROWS; p++) begin
      set_method((p < 4) ? METHOD_W'(3 - p) : METHOD_W'($urandom_range(0, 3)));
      phase_end = rows_sent + RANDOM_ROWS / PHASES;
      while (rows_sent < phase_end) begin
        src_burst = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 4))
          0: miss_pct = 0;
          1: miss_pct = 100;
          2: miss_pct = 50;
          default: miss_pct = 20;
        endcase
        send_pair(($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8),
                  miss_pct);
      end
    end

    row_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
src/mpd_pkg.sv
src/mpd_if.sv
src/mpd_front.sv
src/mpd_queue.sv
src/mpd_div.sv
src/mpd_back.sv
src/masked_pairwise_distance_core.sv
src/mpd_checker.sv
verif/mpd_distance_checker.sv
verif/masked_pairwise_distance_core_tb.sv
